FILE: hdl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Shared widths, register indexes and the divider entry record.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int CW   = 50;
  localparam int NW   = 64;
  localparam int DW   = 48;
  localparam int RW   = 49;
  localparam int QW   = 32;
  localparam int LOWW = 17;
  localparam int MAGW = 63;

  typedef enum logic [2:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_W,
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic            zero;
    logic [RW-1:0]   rem;
    logic [LOWW-1:0] nlow;
    logic [DW-1:0]   den;
  } div_in_t;

endpackage

FILE: hdl/wsp_dot.sv
// ----------------------------------------------------------------------------
// Row dot product
// Two stages: three products and the constant term, then their sum as an exact Q26.24 clip value.
// ----------------------------------------------------------------------------
module wsp_dot (
  input  logic                      clk,
  input  logic                      en,
  input  logic [63:0]               row,
  input  logic signed [31:0]        x,
  input  logic signed [31:0]        y,
  input  logic signed [31:0]        z,
  output logic signed [wsp_pkg::CW-1:0] clip
);
  import wsp_pkg::*;

  logic signed [47:0] p0;
  logic signed [47:0] p1;
  logic signed [47:0] p2;
  logic signed [15:0] k3;

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= $signed(row[15:0]) * x;
      p1   <= $signed(row[31:16]) * y;
      p2   <= $signed(row[47:32]) * z;
      k3   <= $signed(row[63:48]);
      clip <= CW'(p0) + CW'(p1) + CW'(p2) + (CW'(k3) <<< 24);
    end
  end

endmodule

FILE: hdl/wsp_prep.sv
// ----------------------------------------------------------------------------
// Divider setup
// Four stages: numerators, viewport scaling, magnitudes and signs, and the
// first partial remainder with the quotient overflow check.
// ----------------------------------------------------------------------------
module wsp_prep (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [wsp_pkg::CW-1:0] cx,
  input  logic signed [wsp_pkg::CW-1:0] cy,
  input  logic signed [wsp_pkg::CW-1:0] cw,
  input  logic [13:0]                   width,
  input  logic [13:0]                   height,
  output wsp_pkg::div_in_t              dx,
  output wsp_pkg::div_in_t              dy
);
  import wsp_pkg::*;

  logic signed [CW-1:0] sa;
  logic signed [CW-1:0] ta;
  logic signed [CW-1:0] wa;
  logic signed [NW-1:0] nx;
  logic signed [NW-1:0] ny;
  logic signed [CW-1:0] wb;
  logic [MAGW-1:0]      mx;
  logic [MAGW-1:0]      my;
  logic [DW-1:0]        den;
  logic                 negx;
  logic                 negy;
  logic                 zero;
  logic [NW-1:0]        nx_abs;
  logic [NW-1:0]        ny_abs;
  logic [CW-1:0]        w_abs;

  assign nx_abs = nx[NW-1] ? NW'(-nx) : NW'(nx);
  assign ny_abs = ny[NW-1] ? NW'(-ny) : NW'(ny);
  assign w_abs  = wb[CW-1] ? CW'(-wb) : CW'(wb);

  always_ff @(posedge clk) begin
    if (en) begin
      sa   <= cx + cw;
      ta   <= cw - cy;
      wa   <= cw;
      nx   <= sa * $signed({1'b0, width});
      ny   <= ta * $signed({1'b0, height});
      wb   <= wa;
      mx   <= nx_abs[MAGW-1:0];
      my   <= ny_abs[MAGW-1:0];
      den  <= w_abs[DW-1:0];
      negx <= nx[NW-1] ^ wb[CW-1];
      negy <= ny[NW-1] ^ wb[CW-1];
      zero <= (wb == '0);
      dx.neg  <= negx;
      dx.zero <= zero;
      dx.den  <= den;
      dx.nlow <= mx[LOWW-1:0];
      dx.rem  <= RW'(mx[MAGW-1:LOWW]);
      dx.ovf  <= RW'(mx[MAGW-1:LOWW]) >= RW'(den);
      dy.neg  <= negy;
      dy.zero <= zero;
      dy.den  <= den;
      dy.nlow <= my[LOWW-1:0];
      dy.rem  <= RW'(my[MAGW-1:LOWW]);
      dy.ovf  <= RW'(my[MAGW-1:LOWW]) >= RW'(den);
    end
  end

endmodule

FILE: hdl/wsp_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module wsp_div (
  input  logic                 clk,
  input  logic                 en,
  input  wsp_pkg::div_in_t     din,
  output logic signed [31:0]   res,
  output logic                 zero_out
);
  import wsp_pkg::*;

  logic [RW-1:0]   rem  [0:QW];
  logic [QW-1:0]   bits [0:QW];
  logic [QW-1:0]   quo  [0:QW];
  logic [DW-1:0]   den  [0:QW];
  logic            neg  [0:QW];
  logic            ovf  [0:QW];
  logic            zero [0:QW];
  logic [QW:0]     lim;
  logic [QW:0]     mag;

  assign rem[0]  = din.rem;
  assign bits[0] = {din.nlow, (QW - LOWW)'(0)};
  assign quo[0]  = '0;
  assign den[0]  = din.den;
  assign neg[0]  = din.neg;
  assign ovf[0]  = din.ovf;
  assign zero[0] = din.zero;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          take;
    assign trial = {rem[k][RW-2:0], bits[k][QW-1]};
    assign take  = trial >= RW'(den[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? trial - RW'(den[k]) : trial;
        bits[k+1] <= {bits[k][QW-2:0], 1'b0};
        quo[k+1]  <= {quo[k][QW-2:0], take};
        den[k+1]  <= den[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
        zero[k+1] <= zero[k];
      end
    end
  end

  always_comb begin
    lim = neg[QW] ? (QW+1)'(33'h1_0000_0000 >> 1) : (QW+1)'(33'h0_7FFF_FFFF);
    mag = (ovf[QW] || {1'b0, quo[QW]} > lim) ? lim : {1'b0, quo[QW]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_out <= zero[QW];
      if (zero[QW]) begin
        res <= '0;
      end else begin
        res <= neg[QW] ? $signed(QW'(-mag)) : $signed(QW'(mag));
      end
    end
  end

endmodule

FILE: hdl/world_to_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// World-to-screen projection unit
// Projects a Q16.16 world point through three matrix rows and maps the
// quotient to saturated Q16.16 viewport pixels.
//
//   channel | signals                          | direction
//   in      | in_valid, in_stall, pos_x/y/z    | into the block
//   out     | out_valid, out_stall, screen_x/y, w_zero | out of the block
//   cfg     | cfg_we, cfg_index, cfg_data      | into the block
//
// One item per cycle while the output is not stalled, through a 32-stage divider.
// Reset clears the valid bits and loads the register reset values.
// The whole pipeline holds while the output item is stalled.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               w_zero,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import wsp_pkg::*;

  localparam int LAT = 39;

  logic [63:0]          row_x;
  logic [63:0]          row_y;
  logic [63:0]          row_w;
  logic [13:0]          screen_width;
  logic [13:0]          screen_height;
  logic [LAT-1:0]       vld;
  logic                 en;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cw;
  div_in_t              dx;
  div_in_t              dy;
  logic                 zero_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x         <= '0;
      row_y         <= '0;
      row_w         <= '0;
      screen_width  <= 14'd1920;
      screen_height <= 14'd1080;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X:  row_x         <= cfg_data;
        REG_ROW_Y:  row_y         <= cfg_data;
        REG_ROW_W:  row_w         <= cfg_data;
        REG_WIDTH:  screen_width  <= cfg_data[13:0];
        REG_HEIGHT: screen_height <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  assign en        = !vld[LAT-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  wsp_dot u_dot_x (.clk, .en, .row(row_x), .x(pos_x), .y(pos_y), .z(pos_z), .clip(cx));
  wsp_dot u_dot_y (.clk, .en, .row(row_y), .x(pos_x), .y(pos_y), .z(pos_z), .clip(cy));
  wsp_dot u_dot_w (.clk, .en, .row(row_w), .x(pos_x), .y(pos_y), .z(pos_z), .clip(cw));

  wsp_prep u_prep (
    .clk, .en, .cx, .cy, .cw,
    .width(screen_width), .height(screen_height), .dx, .dy
  );

  wsp_div u_div_x (.clk, .en, .din(dx), .res(screen_x), .zero_out(w_zero));
  wsp_div u_div_y (.clk, .en, .din(dy), .res(screen_y), .zero_out(zero_y));

  logic unused_zero;
  assign unused_zero = zero_y;

endmodule

FILE: hdl/wsp_checker.sv
// ----------------------------------------------------------------------------
// Projection unit checker
// Port-level properties of the projection unit, bound to the top level.
// ----------------------------------------------------------------------------
module wsp_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] screen_x,
  input logic signed [31:0] screen_y,
  input logic               w_zero
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(screen_y))
    else $error("Stalled output item changed.");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> screen_x == 0 && screen_y == 0)
    else $error("Zero clip w gave a nonzero position.");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output was free.");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Output item right after reset.");

endmodule

bind world_to_screen_projection_unit wsp_port_checker u_wsp_port_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall,
  .screen_x, .screen_y, .w_zero
);
